[sv/bounded_set_span_tracker_assert.svh]
// ----------------------------------------------------------------------------
// bounded_set_span_tracker_assert.svh
// Assertion macros shared by the span tracker RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_TRACKER_ASSERT_SVH
`define BOUNDED_SET_SPAN_TRACKER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BSST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define BSST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BSST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/bsst_pkg.sv]
// ----------------------------------------------------------------------------
// bsst_pkg
// Types and constants of the bounded set span tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsst_pkg;

    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit
    localparam logic REG_CAPACITY = 1'b0;

    // Shortest span before any pair exists
    localparam logic [VALUE_W-1:0] GAP_INIT = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      batch_last;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic               full_error;
        logic               span_valid;
        logic [VALUE_W-1:0] shortest_span;
        logic [VALUE_W-1:0] longest_span;
        logic [COUNT_W-1:0] stored_count;
        logic               end_of_batch;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[sv/bsst_ram.sv]
// ----------------------------------------------------------------------------
// bsst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/bounded_set_span_tracker.sv]
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Stores signed numbers up to a configured capacity and reports the running
// shortest pairwise span and longest span (max minus min) of the stored set.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    in_data  (value, batch_last)
//   out      source     out_valid/out_ready  out_data (flags, spans, count)
//   cfg      apb slave  psel/penable/pready  capacity at byte address 0
//
// A stored item passes through accept, a scan of one RAM read a cycle over the
// held values (none if the store is empty), a gap unit drain, an update and a
// result state before in_ready returns; a dropped item goes from accept straight
// to its result. Reset clears the counters and spans; the value RAM is never
// cleared, since only written entries are read. A stalled result holds in the
// output register while the next item is accepted and scanned; its result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_set_span_tracker_assert.svh"

module bounded_set_span_tracker
    import bsst_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_t                   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_t                       out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        capacity_reg;
    logic [COUNT_W-1:0]        held_count_reg, held_count_next;
    logic [VALUE_W-1:0]        best_gap_reg, best_gap_next;
    logic signed [VALUE_W-1:0] low_reg, low_next;
    logic signed [VALUE_W-1:0] high_reg, high_next;
    logic [COUNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                      cmp_pend_reg, cmp_pend_next;
    logic                      full_reg, full_next;
    in_t                       item_reg, item_next;
    logic                      out_valid_reg, out_valid_next;
    out_t                      out_data_reg, out_data_next;

    logic                      in_xfer;
    logic                      out_free;
    logic                      full_now;
    logic                      issue;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic [VALUE_W:0]          diff;
    logic [VALUE_W:0]          diff_abs;
    logic [VALUE_W-1:0]        gap;
    logic                      span_ok;
    logic                      cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (cfg_write && paddr[2] == REG_CAPACITY)
        begin
            capacity_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Store is full at the configured capacity or at the RAM depth
    assign full_now = (held_count_reg >= capacity_reg)
                   || (int'(held_count_reg) >= STORE_DEPTH);

    // Scan issues one read a cycle until every held value has been read
    assign issue = (state_reg == ST_SCAN) && (scan_idx_reg < held_count_reg);

    // Value store
    assign ram_we    = (state_reg == ST_UPDATE) && !full_reg;
    assign ram_waddr = ADDR_W'(held_count_reg);
    assign ram_raddr = ADDR_W'(scan_idx_reg);

    bsst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared gap unit: exact |new - stored| in one bit more than the operands
    assign diff     = {item_reg.value[VALUE_W-1], item_reg.value}
                    - {ram_rdata[VALUE_W-1], ram_rdata};
    assign diff_abs = diff[VALUE_W] ? ((VALUE_W+1)'(0) - diff) : diff;
    assign gap      = diff_abs[VALUE_W-1:0];

    assign span_ok  = (held_count_reg >= COUNT_W'(2));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = full_now ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !cmp_pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        held_count_next = held_count_reg;
        best_gap_next   = best_gap_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_pend_next   = 1'b0;
        full_next       = full_reg;
        item_next       = item_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    item_next     = in_data;
                    full_next     = full_now;
                    scan_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                // Advance the read pointer
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    cmp_pend_next = 1'b1;
                end
                // Keep the smaller gap
                if (cmp_pend_reg && gap < best_gap_reg)
                begin
                    best_gap_next = gap;
                end
            end
            ST_UPDATE:
            begin
                // Track the extremes and count the new value
                if (held_count_reg == '0)
                begin
                    low_next  = item_reg.value;
                    high_next = item_reg.value;
                end
                else
                begin
                    if (item_reg.value < low_reg)
                    begin
                        low_next = item_reg.value;
                    end
                    if (high_reg < item_reg.value)
                    begin
                        high_next = item_reg.value;
                    end
                end
                held_count_next = held_count_reg + 1'b1;
            end
            ST_EMIT:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.accepted      = !full_reg;
                    out_data_next.full_error    = full_reg;
                    out_data_next.span_valid    = span_ok;
                    out_data_next.shortest_span = span_ok ? best_gap_reg : '0;
                    out_data_next.longest_span  =
                        span_ok ? VALUE_W'($unsigned(high_reg - low_reg)) : '0;
                    out_data_next.stored_count  = held_count_reg;
                    out_data_next.end_of_batch  = item_reg.batch_last;
                end
            end
            default:
            begin
                cmp_pend_next = 1'b0;
            end
        endcase
    end

    // Control and tracked state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            best_gap_reg   <= GAP_INIT;
            low_reg        <= '0;
            high_reg       <= '0;
            scan_idx_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            full_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            best_gap_reg   <= best_gap_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_pend_reg   <= cmp_pend_next;
            full_reg       <= full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    // Checks
    `BSST_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, int'(held_count_reg) <= STORE_DEPTH, "held count beyond store depth")
    `BSST_ASSERT_NXT(a_held_step, clk, rst_n, state_reg == ST_UPDATE, held_count_reg == COUNT_W'($past(held_count_reg) + 1'b1), "held count did not advance on store")
    `BSST_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid_reg, out_data_reg.accepted != out_data_reg.full_error, "accepted and full flags agree")
    `BSST_ASSERT_IMP(a_span_order, clk, rst_n, out_valid_reg && out_data_reg.span_valid, out_data_reg.longest_span >= out_data_reg.shortest_span, "longest span below shortest span")
    `BSST_ASSERT_NXT(a_busy_after, clk, rst_n, in_xfer, !in_ready, "ready right after an input transfer")

endmodule

`default_nettype wire

[bench/tb_bounded_set_span_tracker.sv]
// ----------------------------------------------------------------------------
// tb_bounded_set_span_tracker
// Self-checking bench for the bounded set span tracker. A local predictor
// keeps its own copy of the held values, the capacity and the running spans,
// and it forms the expected result of every input transfer. A
// checker compares each output transfer field by field with the oldest
// expected result. The stimulus covers directed edge values, capacity
// changes around the held count, randomized bursts under several idle and
// stall patterns, a long output hold-off, and a fill to the programmed
// capacity followed by a capacity beyond the store depth.
// ----------------------------------------------------------------------------
module tb_bounded_set_span_tracker;
    import bsst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH  = 1024;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int BURST_ITEMS  = 130;
    localparam int FILL_ITEMS   = 40;

    // Byte addresses of the register map: capacity and one unmapped word
    localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic signed [VALUE_W-1:0] model_values [STORE_DEPTH];
    int unsigned               model_count;
    logic [VALUE_W-1:0]        model_gap;
    logic signed [VALUE_W-1:0] model_low;
    logic signed [VALUE_W-1:0] model_high;
    logic [COUNT_W-1:0]        model_cap;

    out_t expected_spans [$];

    int err_count     = 0;
    int items_sent    = 0;
    int items_stored  = 0;
    int items_dropped = 0;
    int results_seen  = 0;
    int cap_writes    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int longest_hold  = 0;

    bounded_set_span_tracker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time
    initial
    begin
        #(40_000_000);
        $display("timeout: run did not complete");
        $display("tb: failure");
        $finish;
    end

    // Count a mismatch and print it
    task automatic flag_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want, input int idx);
        if (got !== want)
        begin
            flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                    idx, name, got, want));
        end
    endtask

    // Exact distance of two signed values, taken one bit wider
    function automatic logic [VALUE_W-1:0] pair_gap(input logic signed [VALUE_W-1:0] a,
                                                    input logic signed [VALUE_W-1:0] b);
        logic signed [VALUE_W:0] d;
        d = a - b;
        if (d < 0)
        begin
            d = -d;
        end
        return d[VALUE_W-1:0];
    endfunction

    // Apply one item to the predictor and form its result
    function automatic out_t predict_span(input in_t item);
        out_t                      res;
        int unsigned               limit;
        logic                      is_full;
        logic                      pair_held;
        logic [VALUE_W-1:0]        gap;
        logic signed [VALUE_W-1:0] v;
        v = item.value;
        limit = (model_cap > STORE_DEPTH) ? STORE_DEPTH : model_cap;
        is_full = (model_count >= limit);
        if (!is_full)
        begin
            if (model_count == 0)
            begin
                model_low  = v;
                model_high = v;
            end
            else
            begin
                for (int k = 0; k < model_count; k++)
                begin
                    gap = pair_gap(v, model_values[k]);
                    if (gap < model_gap)
                    begin
                        model_gap = gap;
                    end
                end
                if (v < model_low)
                begin
                    model_low = v;
                end
                if (v > model_high)
                begin
                    model_high = v;
                end
            end
            if (model_count < STORE_DEPTH)
            begin
                model_values[model_count] = v;
                model_count++;
            end
        end
        pair_held = (model_count >= 2);
        res.accepted      = !is_full;
        res.full_error    = is_full;
        res.span_valid    = pair_held;
        res.shortest_span = pair_held ? model_gap : '0;
        res.longest_span  = pair_held ? VALUE_W'(model_high - model_low) : '0;
        res.stored_count  = model_count[COUNT_W-1:0];
        res.end_of_batch  = item.batch_last;
        return res;
    endfunction

    // Offer one item after a random gap and predict it once transferred
    task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic last);
        in_t  item;
        out_t res;
        item.value      = value;
        item.batch_last = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        res = predict_span(item);
        expected_spans.insert(expected_spans.size(), res);
        items_sent++;
        if (res.accepted)
        begin
            items_stored++;
        end
        else
        begin
            items_dropped++;
        end
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (expected_spans.size() != 0 && waited < DRAIN_LIMIT);
        if (expected_spans.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results missing after drain", expected_spans.size()));
        end
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == CAP_ADDR)
        begin
            model_cap = data[COUNT_W-1:0];
        end
        cap_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic read_reg(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Read back the capacity and compare with the predictor's copy
    task automatic check_capacity();
        logic [APB_DATA_W-1:0] got;
        read_reg(CAP_ADDR, got);
        if (got !== APB_DATA_W'(model_cap))
        begin
            flag_mismatch($sformatf("capacity read: got %0h, want %0h", got, model_cap));
        end
    endtask

    task automatic program_capacity(input logic [APB_DATA_W-1:0] data);
        write_reg(CAP_ADDR, data);
        check_capacity();
    endtask

    // Send bursts of evenly stepped values mixed with uniform noise
    task automatic drive_value_bursts(input logic [APB_DATA_W-1:0] cap, input int count);
        int                        sent;
        int                        burst;
        int                        kind;
        logic signed [VALUE_W-1:0] base;
        logic [VALUE_W-1:0]        step;
        logic signed [VALUE_W-1:0] v;
        logic                      last;
        sent = 0;
        program_capacity(cap);
        while (sent < count)
        begin
            burst = $urandom_range(8, 1);
            kind  = $urandom_range(99);
            base  = $urandom;
            step  = $urandom_range(32'h00FF_FFFF, 1);
            // Start some bursts just inside the extremes
            if (kind >= 90)
            begin
                base = $urandom_range(1) ? VALUE_MAX - 1 - $urandom_range(254)
                                         : VALUE_MIN + 1 + $urandom_range(254);
            end
            for (int k = 0; k < burst && sent < count; k++)
            begin
                if (kind >= 60 && kind < 90)
                begin
                    v    = $urandom;
                    last = 1'($urandom_range(1));
                end
                else
                begin
                    v    = base + k * step;
                    last = (k == burst - 1);
                end
                send_item(v, last);
                sent++;
            end
        end
        drain_results();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            if (hold_request > longest_hold)
            begin
                longest_hold = hold_request;
            end
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_spans.size() == 0)
            begin
                flag_mismatch("output transfer with nothing expected");
            end
            else
            begin
                want = expected_spans.pop_front();
                compare_field("accepted", out_data.accepted, want.accepted, results_seen);
                compare_field("full_error", out_data.full_error, want.full_error, results_seen);
                compare_field("span_valid", out_data.span_valid, want.span_valid, results_seen);
                compare_field("shortest_span", out_data.shortest_span, want.shortest_span,
                              results_seen);
                compare_field("longest_span", out_data.longest_span, want.longest_span,
                              results_seen);
                compare_field("stored_count", out_data.stored_count, want.stored_count,
                              results_seen);
                compare_field("end_of_batch", out_data.end_of_batch, want.end_of_batch,
                              results_seen);
            end
            results_seen++;
        end
    end

    // Extremes, capacity below the held count, unmapped register, masking
    task automatic test_directed_edges();
        send_idle_pct = 0;
        stall_pct     = 0;
        check_capacity();
        // Capacity zero after reset: drop
        send_item(5, 1'b1);
        drain_results();
        program_capacity(1);
        send_item(VALUE_MIN, 1'b0);
        send_item(7, 1'b1);
        drain_results();
        // Widest possible pair
        program_capacity(2);
        send_item(VALUE_MAX, 1'b1);
        drain_results();
        // Capacity below the held count keeps the spans valid
        program_capacity(1);
        send_item(-1, 1'b0);
        drain_results();
        program_capacity(0);
        send_item(0, 1'b1);
        drain_results();
        // Unmapped word must leave the capacity alone
        write_reg(SPARE_ADDR, 32'h0000_07FF);
        check_capacity();
        send_item(3, 1'b0);
        drain_results();
        // Upper data bits are masked off
        program_capacity(32'hFFFF_F806);
        send_item(0, 1'b1);
        send_item(32'sh4000_0000, 1'b0);
        send_item(32'shC000_0000, 1'b1);
        send_item(32'sh2000_0000, 1'b0);
        send_item(12345, 1'b1);
        drain_results();
    endtask

    // Back-to-back input while the receiver holds off
    task automatic test_random_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = HOLD_CYCLES;
        drive_value_bursts(80, BURST_ITEMS);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 63;
        stall_pct     = 0;
        drive_value_bursts(160, BURST_ITEMS);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct = 0;
        stall_pct     = 63;
        drive_value_bursts(260, BURST_ITEMS);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct = 11;
        stall_pct     = 11;
        drive_value_bursts(360, BURST_ITEMS);
    endtask

    // Fill up to a raised capacity, repeat one held value, drop past it,
    // then open the capacity beyond the store depth
    task automatic test_fill_and_saturate();
        logic signed [VALUE_W-1:0] v;
        int unsigned               target;
        send_idle_pct = 11;
        stall_pct     = 11;
        target = model_count + FILL_ITEMS;
        program_capacity(APB_DATA_W'(target));
        while (model_count < target)
        begin
            v = $urandom;
            if (model_count == target - 1)
            begin
                v = model_values[$urandom_range(model_count - 1)];
            end
            send_item(v, 1'($urandom_range(1)));
        end
        for (int k = 0; k < 3; k++)
        begin
            send_item($urandom, 1'($urandom_range(1)));
        end
        drain_results();
        // All ones: capacity beyond the store depth
        program_capacity(32'hFFFF_FFFF);
        for (int k = 0; k < 3; k++)
        begin
            send_item($urandom, 1'($urandom_range(1)));
        end
        drain_results();
    endtask

    initial
    begin
        model_count = 0;
        model_gap   = GAP_INIT;
        model_low   = '0;
        model_high  = '0;
        model_cap   = '0;

        // Hold reset for the opening cycles
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_random_backpressure();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_fill_and_saturate();

        // Let any stray result show up before the verdict
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_spans.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    expected_spans.size()));
        end

        $display("summary: %0d items offered, %0d stored, %0d dropped, %0d results checked",
                 items_sent, items_stored, items_dropped, results_seen);
        $display("summary: %0d register writes, store filled to %0d, hold-off of %0d cycles",
                 cap_writes, model_count, longest_hold);
        if (err_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
